// ===== sv/rsg_pkg.sv =====
package rsg_pkg;

  localparam int unsigned STORE_DEPTH = 16;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned RUN_W       = 16;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(16);
  localparam logic [RUN_W-1:0] RUN_MAX    = '1;
  localparam logic [RUN_W-1:0] RUN_FIRST  = RUN_W'(1);

  // One slot of the chain; frozen keys sort after all live keys.
  typedef struct packed {
    logic                    valid;
    logic                    frz;
    logic signed [KEY_W-1:0] key;
  } entry_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic ins;      // place the new entry
    logic pop;      // drop the head, everything moves one cell towards it
    logic clr_frz;  // frozen keys become the live keys of the next run
  } chain_op_t;

  // True when a sorts strictly before b.
  function automatic logic entry_before(entry_t a, entry_t b);
    logic res;
    if (a.frz != b.frz) begin
      res = b.frz;
    end else begin
      res = (a.key < b.key);
    end
    return res;
  endfunction

endpackage

// ===== sv/rsg_if.sv =====
interface rsg_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsg_pkg::KEY_W-1:0]  value;
  logic                              is_final;

  modport source (output valid, output value, output is_final, input ready);
  modport sink   (input valid, input value, input is_final, output ready);
endinterface

interface rsg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsg_pkg::KEY_W-1:0]  key_out;
  logic        [rsg_pkg::RUN_W-1:0]  run_number;
  logic                              stream_done;

  modport source (output valid, output key_out, output run_number, output stream_done,
                  input ready);
  modport sink   (input valid, input key_out, input run_number, input stream_done,
                  output ready);
endinterface

// ===== sv/rsg_cell.sv =====
module rsg_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsg_pkg::chain_op_t op_i,
  input  rsg_pkg::entry_t    new_i,
  input  rsg_pkg::entry_t    left_i,
  input  logic               left_flag_i,
  input  rsg_pkg::entry_t    right_i,
  output rsg_pkg::entry_t    entry_o,
  output logic               flag_o
);
  import rsg_pkg::*;

  logic                    valid_q, valid_d;
  logic                    frz_q, frz_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  entry_t                  own;
  entry_t                  nxt;

  assign own     = '{valid: valid_q, frz: frz_q, key: key_q};
  assign entry_o = own;

  // Flag: the entry that will sit here (before the new one lands) stays ahead of it.
  always_comb begin
    if (op_i.pop) begin
      flag_o = right_i.valid && !entry_before(new_i, right_i);
    end else begin
      flag_o = own.valid && !entry_before(new_i, own);
    end
  end

  always_comb begin
    if (op_i.ins) begin
      if (flag_o) begin
        nxt = op_i.pop ? right_i : own;
      end else if (left_flag_i) begin
        nxt = new_i;
      end else begin
        nxt = op_i.pop ? own : left_i;
      end
    end else if (op_i.pop) begin
      nxt = right_i;
    end else begin
      nxt = own;
    end
    valid_d = nxt.valid;
    frz_d   = nxt.frz && !op_i.clr_frz;
    key_d   = nxt.key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      frz_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      frz_q   <= frz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

// ===== sv/replacement_selection_run_generator.sv =====
// Channel   Dir  Payload                               Transfer
// in_i      in   value, is_final                       valid & ready
// out_o     out  key_out, run_number, stream_done      valid & ready
// cfg       in   cfg_wdata_i (store size)              cfg_we_i
//
// Keys sit in a sorted chain of STORE_DEPTH cells, live keys first. One item per cycle
// while out_o takes results; any item waits while the output register holds a result
// that out_o has not taken. A result leaves the cycle after the transfer that causes it.
// A final item is followed by a flush that emits each held key (1..STORE_DEPTH) while
// out_o takes results, during which in_i.ready is low. Reset empties the chain at once.
module replacement_selection_run_generator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rsg_pkg::CFG_W-1:0] cfg_wdata_i,
  rsg_in_if.sink                    in_i,
  rsg_out_if.source                 out_o
);
  import rsg_pkg::*;

  logic [CFG_W-1:0] size_q;
  logic [CNT_W-1:0] cnt_q, cnt_d, live_q, live_d;
  logic [CNT_W-1:0] cnt_nx, live_nx;
  logic [RUN_W-1:0] run_q, run_d;
  logic             flush_q, flush_d;

  logic                    out_valid_q;
  logic signed [KEY_W-1:0] out_key_q;
  logic [RUN_W-1:0]        out_run_q;
  logic                    out_done_q;

  logic [CMP_W-1:0] size_eff;
  logic             full, out_free, acc, flush_pop, emit, promote, stream_end;
  entry_t           new_e;
  entry_t           head;
  chain_op_t        op;

  entry_t cells [STORE_DEPTH];
  logic   flags [STORE_DEPTH];

  always_comb begin
    if (CMP_W'(size_q) > CMP_W'(STORE_DEPTH)) begin
      size_eff = CMP_W'(STORE_DEPTH);
    end else if (size_q == '0) begin
      size_eff = CMP_W'(1);
    end else begin
      size_eff = CMP_W'(size_q);
    end
  end

  assign head      = cells[0];
  assign full      = CMP_W'(cnt_q) >= size_eff;
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = !flush_q && out_free;
  assign acc       = in_i.valid && in_i.ready;
  assign flush_pop = flush_q && out_free;
  assign emit      = (acc && full) || flush_pop;

  // A key below the one leaving now waits for the next run.
  assign new_e = '{valid: 1'b1, frz: full && (in_i.value < head.key), key: in_i.value};

  always_comb begin
    cnt_nx  = cnt_q;
    live_nx = live_q;
    if (acc) begin
      if (full) begin
        live_nx = new_e.frz ? live_q - CNT_W'(1) : live_q;
      end else begin
        cnt_nx  = cnt_q + CNT_W'(1);
        live_nx = live_q + CNT_W'(1);
      end
    end else if (flush_pop) begin
      cnt_nx  = cnt_q - CNT_W'(1);
      live_nx = live_q - CNT_W'(1);
    end
  end

  assign stream_end = flush_pop && (cnt_nx == '0);
  assign promote    = (live_nx == '0) && (cnt_nx != '0);

  always_comb begin
    op.ins     = acc;
    op.pop     = emit;
    op.clr_frz = promote;
    cnt_d      = cnt_nx;
    live_d     = promote ? cnt_nx : live_nx;
    run_d      = run_q;
    flush_d    = flush_q;
    if (promote && run_q != RUN_MAX) begin
      run_d = run_q + RUN_W'(1);
    end
    if (acc && in_i.is_final) begin
      flush_d = 1'b1;
    end
    if (stream_end) begin
      flush_d = 1'b0;
      run_d   = RUN_FIRST;
    end
  end

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_f;
    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_f = 1'b1;
    end else begin : g_mid
      assign left_e = cells[i-1];
      assign left_f = flags[i-1];
    end
    if (i == STORE_DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cells[i+1];
    end
    rsg_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .new_i       (new_e),
      .left_i      (left_e),
      .left_flag_i (left_f),
      .right_i     (right_e),
      .entry_o     (cells[i]),
      .flag_o      (flags[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RESET;
      cnt_q       <= '0;
      live_q      <= '0;
      run_q       <= RUN_FIRST;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      cnt_q       <= cnt_d;
      live_q      <= live_d;
      run_q       <= run_d;
      flush_q     <= flush_d;
      out_valid_q <= emit || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_key_q  <= head.key;
      out_run_q  <= run_q;
      out_done_q <= stream_end;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.key_out     = out_key_q;
  assign out_o.run_number  = out_run_q;
  assign out_o.stream_done = out_done_q;

endmodule

// ===== dv/tb_replacement_selection_run_generator.sv =====
module tb_replacement_selection_run_generator;
  import rsg_pkg::*;

  localparam int SETTLE_CYCLES = STORE_DEPTH + 4;
  localparam int MAX_REPORTS   = 60;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [RUN_W-1:0]        run;
    logic                    done;
  } sorted_key_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  rsg_in_if  in_if ();
  rsg_out_if out_if ();

  replacement_selection_run_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predictor state
  logic signed [KEY_W-1:0] held_live [STORE_DEPTH];
  logic signed [KEY_W-1:0] held_frozen [STORE_DEPTH];
  int                      n_live;
  int                      n_frozen;
  logic [RUN_W-1:0]        run_ctr;
  logic [CFG_W-1:0]        store_size;
  sorted_key_t             keys_due [$];

  int          fails;
  int          send_idle_pct;
  int          recv_stall_pct;
  sorted_key_t due_key;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic signed [KEY_W-1:0] take_lowest_live();
    int                      best;
    logic signed [KEY_W-1:0] lo;
    best = 0;
    for (int k = 1; k < n_live; k++) begin
      if (held_live[k] < held_live[best]) begin
        best = k;
      end
    end
    lo = held_live[best];
    held_live[best] = held_live[n_live-1];
    n_live--;
    return lo;
  endfunction

  function automatic void start_next_run();
    for (int k = 0; k < STORE_DEPTH; k++) begin
      held_live[k] = held_frozen[k];
    end
    n_live   = n_frozen;
    n_frozen = 0;
    if (run_ctr != RUN_MAX) begin
      run_ctr++;
    end
  endfunction

  function automatic void note_key(logic signed [KEY_W-1:0] k);
    keys_due.push_back('{key: k, run: run_ctr, done: 1'b0});
  endfunction

  function automatic void predict_keys(logic signed [KEY_W-1:0] v, logic fin);
    int                      eff;
    int                      emitted;
    logic signed [KEY_W-1:0] lo;
    eff     = int'(store_size);
    emitted = 0;
    if (eff < 1) begin
      eff = 1;
    end
    if (eff > int'(STORE_DEPTH)) begin
      eff = int'(STORE_DEPTH);
    end
    if (n_live + n_frozen < eff) begin
      held_live[n_live] = v;
      n_live++;
    end else begin
      if (n_live == 0) begin
        start_next_run();
      end
      lo = take_lowest_live();
      note_key(lo);
      emitted++;
      // keys below the one just emitted wait for the next run
      if (v < lo) begin
        held_frozen[n_frozen] = v;
        n_frozen++;
      end else begin
        held_live[n_live] = v;
        n_live++;
      end
      if (n_live == 0 && n_frozen > 0) begin
        start_next_run();
      end
    end
    if (fin) begin
      while (n_live > 0) begin
        note_key(take_lowest_live());
        emitted++;
      end
      if (n_frozen > 0) begin
        start_next_run();
        while (n_live > 0) begin
          note_key(take_lowest_live());
          emitted++;
        end
      end
      if (emitted > 0) begin
        keys_due[keys_due.size()-1].done = 1'b1;
      end
      n_live   = 0;
      n_frozen = 0;
      run_ctr  = RUN_FIRST;
    end
  endfunction

  // Receiver: random stalls, decided at the falling edge
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (keys_due.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS) begin
          $display("%0t: result with nothing expected: key %0d run %0d done %0b", $time,
                   out_if.key_out, out_if.run_number, out_if.stream_done);
        end
      end else begin
        due_key = keys_due.pop_front();
        if (out_if.key_out !== due_key.key) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("%0t: key_out expected %0d actual %0d", $time, due_key.key,
                     out_if.key_out);
          end
        end
        if (out_if.run_number !== due_key.run) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("%0t: run_number expected %0d actual %0d", $time, due_key.run,
                     out_if.run_number);
          end
        end
        if (out_if.stream_done !== due_key.done) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("%0t: stream_done expected %0b actual %0b", $time, due_key.done,
                     out_if.stream_done);
          end
        end
      end
    end
  end

  task automatic send_key(input logic signed [KEY_W-1:0] v, input logic fin);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    = 1'b1;
    in_if.value    = v;
    in_if.is_final = fin;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    predict_keys(v, fin);
  endtask

  // Sender holds off until every expected key has been seen, then lets the
  // chain finish any flush or fill still in flight.
  task automatic settle_store();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (keys_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] sz);
    settle_store();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = sz;
    @(posedge clk_i);
    store_size = sz;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic test_short_streams();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_key(32'sd0, 1'b1);
    send_key(32'sh7fffffff, 1'b0);
    send_key(32'sh80000000, 1'b0);
    send_key(-32'sd1, 1'b0);
    send_key(32'sd0, 1'b1);
  endtask

  task automatic test_size_extremes();
    write_size(CFG_W'(1));
    send_key(32'sd5, 1'b0);
    send_key(32'sd3, 1'b0);
    send_key(32'sd9, 1'b0);
    send_key(32'sd9, 1'b0);
    send_key(-32'sd7, 1'b1);
    // zero behaves as one, oversize values clamp to the full store
    write_size(CFG_W'(0));
    send_key(32'sd2, 1'b0);
    send_key(32'sd1, 1'b0);
    send_key(32'sd0, 1'b1);
    write_size(CFG_W'(31));
    send_key(32'sd4, 1'b0);
    send_key(32'sd1, 1'b1);
    write_size(CFG_W'(17));
    send_key(32'sh80000000, 1'b1);
  endtask

  task automatic test_equal_keys();
    write_size(CFG_W'(2));
    send_key(32'sd4, 1'b0);
    send_key(32'sd4, 1'b0);
    send_key(32'sd4, 1'b0);
    send_key(32'sd2, 1'b0);
    send_key(32'sd4, 1'b1);
  endtask

  task automatic test_resize_midstream();
    write_size(CFG_W'(4));
    send_key(32'sd10, 1'b0);
    send_key(32'sd20, 1'b0);
    send_key(32'sd30, 1'b0);
    send_key(32'sd40, 1'b0);
    send_key(32'sd5, 1'b0);
    write_size(CFG_W'(2));
    send_key(32'sd1, 1'b0);
    send_key(32'sd50, 1'b0);
    write_size(CFG_W'(5));
    send_key(32'sd7, 1'b0);
    send_key(32'sd8, 1'b1);
  endtask

  // Size one with falling keys opens a new run on every transfer after the first.
  task automatic test_falling_keys();
    logic signed [KEY_W-1:0] k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_size(CFG_W'(1));
    k = 32'sh7fffffff;
    for (int i = 0; i < 12; i++) begin
      send_key(k, i == 11);
      k = k - 32'sd1;
    end
  endtask

  task automatic test_random_streams(input int items, input int idle_pct, input int stall_pct);
    int                      sent;
    int                      len;
    int                      mode;
    logic signed [KEY_W-1:0] v;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent           = 0;
    v              = '0;
    while (sent < items) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0: write_size(CFG_W'(1));
          1: write_size(CFG_W'(STORE_DEPTH));
          2: write_size(CFG_W'($urandom_range(2, 6)));
          default: write_size(CFG_W'($urandom_range(31)));
        endcase
      end
      mode = $urandom_range(3);
      len  = $urandom_range(1, 24);
      if (len > items - sent) begin
        len = items - sent;
      end
      v    = $urandom;
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: v = $urandom;
          1: v = $signed($urandom_range(16)) - 32'sd8;
          // drifting downwards: many frozen keys and run changes
          2: v = v - $signed($urandom_range(6)) + 32'sd2;
          default: begin
            case ($urandom_range(5))
              0: v = 32'sh80000000;
              1: v = 32'sh7fffffff;
              2: v = 32'sd0;
              3: v = -32'sd1;
              4: v = 32'sh80000001;
              default: v = 32'sh7ffffffe;
            endcase
          end
        endcase
        if ($urandom_range(19) == 0) begin
          settle_store();
        end
        send_key(v, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    fails          = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_if.valid    = 1'b0;
    in_if.value    = '0;
    in_if.is_final = 1'b0;
    n_live         = 0;
    n_frozen       = 0;
    run_ctr        = RUN_FIRST;
    store_size     = SIZE_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_short_streams();
    test_size_extremes();
    test_equal_keys();
    test_resize_midstream();
    test_falling_keys();
    test_random_streams(30, 0, 0);
    test_random_streams(30, 79, 0);
    test_random_streams(30, 0, 79);
    test_random_streams(30, 13, 13);

    settle_store();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rsg_pkg.sv
sv/rsg_if.sv
sv/rsg_cell.sv
sv/replacement_selection_run_generator.sv
dv/tb_replacement_selection_run_generator.sv
